>>> src/ara_pkg.sv
//==============================================================================
// ara_pkg
// Shared types, widths and the CORDIC arctangent table for the axis rotation
// accumulator.
//==============================================================================
`default_nettype none

package ara_pkg;

   localparam int DATAW        = 32;  // matrix entry / pivot width
   localparam int OPW          = 34;  // multiplier operand width
   localparam int PRODW        = 2 * OPW;
   localparam int ACCW         = PRODW + 2;
   localparam int XYW          = 34;  // CORDIC x/y, Q2.30 with headroom
   localparam int ZW           = 33;  // CORDIC residual angle
   localparam int CORDIC_STEPS = 30;
   localparam int STEPW        = 5;
   localparam logic signed [XYW-1:0] CORDIC_GAIN = XYW'(652032874);

   localparam logic [1:0] AXIS_X     = 2'd0;
   localparam logic [1:0] AXIS_Y     = 2'd1;
   localparam logic [1:0] AXIS_Z     = 2'd2;
   localparam logic [1:0] AXIS_Z_ALT = 2'd3;  // also rotates about z
   localparam logic       OP_WORLD   = 1'b0;
   localparam logic       OP_LOCAL   = 1'b1;

   // register indexes on the csr channel
   localparam logic [1:0] REG_PIVOT_X = 2'd0;
   localparam logic [1:0] REG_PIVOT_Y = 2'd1;
   localparam logic [1:0] REG_PIVOT_Z = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_MAC,
      ST_FIN,
      ST_EMIT,
      ST_COMMIT
   } state_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [31:0] atan_entry(input logic [STEPW-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2F9;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         5'd28:   v = 32'h00000003;
         5'd29:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> src/ara_if.sv
//==============================================================================
// ara_if
// Valid/ready channel interfaces: rotation request, row response and
// register write.
//==============================================================================
`default_nettype none

interface ara_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [1:0]  axis;
   logic [15:0] angle;
   modport source (output valid, operation, axis, angle, input ready);
   modport sink   (input valid, operation, axis, angle, output ready);
endinterface

interface ara_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         row_index;
   logic signed [31:0] col0;
   logic signed [31:0] col1;
   logic signed [31:0] col2;
   logic signed [31:0] col3;
   logic               last;
   modport source (output valid, row_index, col0, col1, col2, col3, last, input ready);
   modport sink   (input valid, row_index, col0, col1, col2, col3, last, output ready);
endinterface

interface ara_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/ara_cordic.sv
//==============================================================================
// ara_cordic
// Iterative CORDIC: one rotation step per cycle, then rounding, clamping and
// quadrant mapping to cos/sin in FRAC_BITS fixed point.
//==============================================================================
`default_nettype none

module ara_cordic import ara_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [15:0]           angle,
   output logic                       done,
   output logic signed [OPW-1:0]      cs,
   output logic signed [OPW-1:0]      sn
);

   localparam int SHIFT = 30 - FRAC_BITS;
   localparam int ROUND = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
   localparam int ONE_I = 1 << FRAC_BITS;

   logic                  busy_ff, busy_in;
   logic                  fin_ff, fin_in;
   logic                  done_ff, done_in;
   logic [STEPW-1:0]      step_ff, step_in;
   logic signed [XYW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic [1:0]            quad_ff, quad_in;
   logic signed [OPW-1:0] cs_ff, cs_in, sn_ff, sn_in;

   logic [31:0]           phase;
   logic signed [XYW-1:0] dx, dy;
   logic signed [ZW-1:0]  at;
   logic signed [OPW-1:0] c_fx, s_fx;

   function automatic logic signed [OPW-1:0] to_fx(input logic signed [XYW-1:0] v);
      logic signed [XYW:0] r;
      r = $signed({v[XYW-1], v}) + (XYW+1)'(ROUND);
      r = r >>> SHIFT;
      if (r > (XYW+1)'(ONE_I))
         r = (XYW+1)'(ONE_I);
      if (r < -((XYW+1)'(ONE_I)))
         r = -((XYW+1)'(ONE_I));
      return OPW'(r);
   endfunction

   assign phase = 32'({16'd0, angle} << (32 - ANGLE_BITS));
   assign dx    = y_ff >>> step_ff;
   assign dy    = x_ff >>> step_ff;
   assign at    = $signed({1'b0, atan_entry(step_ff)});
   assign c_fx  = to_fx(x_ff);
   assign s_fx  = to_fx(y_ff);

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      quad_in = quad_ff;
      cs_in   = cs_ff;
      sn_in   = sn_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         z_in    = $signed({3'b000, phase[29:0]});
         quad_in = phase[31:30];
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
         step_in = step_ff + STEPW'(1);
         if (step_ff == STEPW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         case (quad_ff)
            2'd0: begin
               cs_in = c_fx;
               sn_in = s_fx;
            end
            2'd1: begin
               cs_in = -s_fx;
               sn_in = c_fx;
            end
            2'd2: begin
               cs_in = -c_fx;
               sn_in = -s_fx;
            end
            default: begin
               cs_in = s_fx;
               sn_in = -c_fx;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
      cs_ff   <= cs_in;
      sn_ff   <= sn_in;
   end

   assign done = done_ff;
   assign cs   = cs_ff;
   assign sn   = sn_ff;

endmodule

`default_nettype wire

>>> src/axis_rotation_accumulator.sv
//==============================================================================
// axis_rotation_accumulator
// Accumulates axis rotations (about the origin or a pivot) into a 4x4
// homogeneous Q16.16 matrix and returns the updated rows.
//==============================================================================
//  channel | dir | payload                                   | per transaction
//  req     | in  | operation, axis, angle                    | one rotation
//  rsp     | out | row_index, col0..col3, last               | one matrix row
//  csr     | in  | index, data                               | one pivot write
//
//  A rotation runs the CORDIC (one step per cycle), then one dot product
//  per entry on the single shared multiplier: 16 entries, plus 3
//  translations in pivot mode, with each row handed to the output
//  register. The commit state follows, then the idle state, which accepts
//  the next request.
//  req.ready is high only between transactions.
//  Reset is synchronous; the matrix returns to identity, pivot to zero.
//  Rows go out through an output register; a stalled rsp holds the sequencer
//  only when the next row is ready and the register is still full.
//==============================================================================
`default_nettype none

module axis_rotation_accumulator import ara_pkg::*; #(
   parameter int FRAC_BITS  = 16,
   parameter int ANGLE_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ara_req_if.sink    req,
   ara_rsp_if.source  rsp,
   ara_csr_if.sink    csr
);

   localparam logic signed [OPW-1:0] ONE  = OPW'(1) << FRAC_BITS;
   localparam logic signed [ACCW-1:0] HALF = ACCW'(1) << (FRAC_BITS - 1);

   state_type state_ff, state_in;

   logic signed [DATAW-1:0] pivot_ff [3];
   logic signed [DATAW-1:0] om_ff [16];
   logic signed [DATAW-1:0] newm_ff [16];
   logic signed [DATAW-1:0] trans_ff [3];
   logic signed [DATAW-1:0] row_ff [4];

   logic             local_ff;
   logic [1:0]       axis_ff;
   logic             tpass_ff;
   logic [1:0]       i_ff, j_ff;
   logic [2:0]       k_ff;
   logic signed [OPW-1:0]   cs_ff, sn_ff;
   logic signed [PRODW-1:0] prod_ff;
   logic signed [ACCW-1:0]  acc_ff;

   logic                    rsp_valid_ff;
   logic [1:0]              rsp_row_ff;
   logic signed [DATAW-1:0] rsp_col_ff [4];

   logic                    cordic_start, cordic_done;
   logic signed [OPW-1:0]   cordic_cs, cordic_sn;
   logic signed [OPW-1:0]   r_ik, op_a, op_b;
   logic signed [ACCW-1:0]  rnd;
   logic signed [DATAW-1:0] res;
   logic                    out_free;
   logic                    req_accept;

   function automatic logic signed [OPW-1:0] r_entry(
      input logic [1:0] ax, input logic [3:0] idx,
      input logic signed [OPW-1:0] c, input logic signed [OPW-1:0] s,
      input logic signed [DATAW-1:0] t0, input logic signed [DATAW-1:0] t1,
      input logic signed [DATAW-1:0] t2);
      logic signed [OPW-1:0] v;
      v = (idx[1:0] == idx[3:2]) ? ONE : '0;
      case (idx)
         4'd3:    v = OPW'(t0);
         4'd7:    v = OPW'(t1);
         4'd11:   v = OPW'(t2);
         default: ;
      endcase
      case (ax)
         AXIS_X: begin
            case (idx)
               4'd5:    v = c;
               4'd6:    v = s;
               4'd9:    v = -s;
               4'd10:   v = c;
               default: ;
            endcase
         end
         AXIS_Y: begin
            case (idx)
               4'd0:    v = c;
               4'd2:    v = s;
               4'd8:    v = -s;
               4'd10:   v = c;
               default: ;
            endcase
         end
         default: begin
            case (idx)
               4'd0:    v = c;
               4'd1:    v = -s;
               4'd4:    v = s;
               4'd5:    v = c;
               default: ;
            endcase
         end
      endcase
      return v;
   endfunction

   ara_cordic #(
      .FRAC_BITS  (FRAC_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (req.angle),
      .done  (cordic_done),
      .cs    (cordic_cs),
      .sn    (cordic_sn)
   );

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req.valid) state_in = ST_CORDIC;
         ST_CORDIC: if (cordic_done) state_in = ST_MAC;
         ST_MAC:    if (k_ff == 3'd4) state_in = ST_FIN;
         ST_FIN: begin
            if (!tpass_ff && j_ff == 2'd3)
               state_in = ST_EMIT;
            else
               state_in = ST_MAC;
         end
         ST_EMIT: begin
            if (out_free)
               state_in = (i_ff == 2'd3) ? ST_COMMIT : ST_MAC;
         end
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready    = (state_ff == ST_IDLE);
      cordic_start = (state_ff == ST_IDLE) && req.valid;
      csr.ready    = 1'b1;
   end

   // shared multiplier operands
   always_comb begin
      r_ik = r_entry(axis_ff, {i_ff, k_ff[1:0]}, cs_ff, sn_ff,
                     trans_ff[0], trans_ff[1], trans_ff[2]);
      if (tpass_ff) begin
         // (I - R3) row i against the pivot
         if (k_ff[1:0] == 2'd3) begin
            op_a = '0;
            op_b = '0;
         end else begin
            op_a = ((k_ff[1:0] == i_ff) ? ONE : '0) - r_ik;
            op_b = OPW'(pivot_ff[k_ff[1:0]]);
         end
      end else begin
         op_a = r_ik;
         op_b = OPW'(om_ff[{k_ff[1:0], j_ff}]);
      end
   end

   // round half up, then saturate
   always_comb begin
      rnd = (acc_ff + HALF) >>> FRAC_BITS;
      if (rnd > ACCW'(32'sh7FFFFFFF))
         res = 32'sh7FFFFFFF;
      else if (rnd < -ACCW'(33'sh080000000))
         res = 32'sh80000000;
      else
         res = DATAW'(rnd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < 3; n++)
            pivot_ff[n] <= '0;
         for (int n = 0; n < 16; n++)
            om_ff[n] <= (n % 5 == 0) ? DATAW'(ONE) : '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid && csr.ready && csr.index <= REG_PIVOT_Z)
            pivot_ff[csr.index] <= csr.data;
         if (rsp_valid_ff && rsp.ready)
            rsp_valid_ff <= 1'b0;
         if (state_ff == ST_EMIT && out_free)
            rsp_valid_ff <= 1'b1;
         if (state_ff == ST_COMMIT)
            for (int n = 0; n < 16; n++)
               om_ff[n] <= newm_ff[n];
      end

      if (req_accept) begin
         local_ff <= req.operation;
         axis_ff  <= req.axis;
         for (int n = 0; n < 3; n++)
            trans_ff[n] <= '0;
      end

      case (state_ff)
         ST_CORDIC: begin
            cs_ff    <= cordic_cs;
            sn_ff    <= cordic_sn;
            tpass_ff <= (local_ff == OP_LOCAL);
            i_ff     <= '0;
            j_ff     <= '0;
            k_ff     <= '0;
         end
         ST_MAC: begin
            if (k_ff != 3'd4)
               prod_ff <= op_a * op_b;
            acc_ff <= (k_ff == 3'd0) ? '0 : acc_ff + ACCW'(prod_ff);
            k_ff   <= k_ff + 3'd1;
         end
         ST_FIN: begin
            k_ff <= '0;
            if (tpass_ff) begin
               trans_ff[i_ff] <= res;
               if (i_ff == 2'd2) begin
                  tpass_ff <= 1'b0;
                  i_ff     <= '0;
               end else begin
                  i_ff <= i_ff + 2'd1;
               end
            end else begin
               newm_ff[{i_ff, j_ff}] <= res;
               row_ff[j_ff]          <= res;
               if (j_ff != 2'd3)
                  j_ff <= j_ff + 2'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_row_ff <= i_ff;
               for (int n = 0; n < 4; n++)
                  rsp_col_ff[n] <= row_ff[n];
               i_ff <= i_ff + 2'd1;
               j_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.row_index = rsp_row_ff;
   assign rsp.col0      = rsp_col_ff[0];
   assign rsp.col1      = rsp_col_ff[1];
   assign rsp.col2      = rsp_col_ff[2];
   assign rsp.col3      = rsp_col_ff[3];
   assign rsp.last      = (rsp_row_ff == 2'd3);

   // a new request starts the CORDIC in the next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_CORDIC)
      else $error("request not followed by CORDIC");

   // the matrix is only committed right after the last row went out
   a_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |-> $past(state_ff) == ST_EMIT && rsp_row_ff == 2'd3)
      else $error("commit without final row");

   // the dot-product step counter never overruns
   a_kmax: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MAC |-> k_ff <= 3'd4)
      else $error("MAC step counter overrun");

   // a row is loaded only into a free output register
   a_noover: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> $stable(rsp_row_ff))
      else $error("pending row overwritten");

endmodule

`default_nettype wire
